// ===== design/combined_lcg_shuffle_rng_core_macros.svh =====
// ----------------------------------------------------------------------------
// combined lcg shuffle generator assertion macros
// concurrent check wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef COMBINED_LCG_SHUFFLE_RNG_CORE_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define CLSR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define CLSR_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CLSR_ASSERT(name, clk, rst_n, prop, msg)
`define CLSR_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/clsr_pkg.sv =====
// ----------------------------------------------------------------------------
// clsr_pkg
// shared constants, controller states and control buses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clsr_pkg;

  localparam int unsigned DEV_W  = 31;
  localparam int unsigned PROD_W = 47;
  localparam int unsigned FOLD_W = 32;

  // moduli are 2^31 minus a small offset, which makes folding cheap
  localparam logic [31:0] MOD1 = 32'd2147483563;
  localparam logic [31:0] MOD2 = 32'd2147483399;
  localparam logic [7:0]  OFS1 = 8'd85;
  localparam logic [7:0]  OFS2 = 8'd249;
  localparam logic [15:0] MUL1 = 16'd40014;
  localparam logic [15:0] MUL2 = 16'd40692;

  localparam logic [DEV_W-1:0] GEN1_RST = 31'd1;
  localparam logic [DEV_W-1:0] GEN2_RST = 31'd123456789;

  // reciprocal scaling for the table index estimate
  localparam int unsigned IDX_SHIFT = 38;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_W_MUL,
    ST_W_FOLD,
    ST_W_RED,
    ST_D_MUL,
    ST_D_FOLD,
    ST_D_RED,
    ST_D_OUT
  } clsr_state_e;

  typedef struct packed {
    logic seed_ld;
    logic mul_en;
    logic fold_en;
    logic red_g1;
    logic red_g2;
    logic warm_wr;
    logic mem_rd;
    logic out_wr;
  } clsr_cmd_t;

  typedef struct packed {
    logic step_zero;
    logic out_pend;
  } clsr_status_t;

  // first fold: high part times offset plus low 31 bits
  function automatic logic [FOLD_W-1:0] fold_prod(input logic [PROD_W-1:0] p,
                                                  input logic [7:0]        ofs);
    return FOLD_W'(p[PROD_W-1:DEV_W]) * FOLD_W'(ofs) + FOLD_W'(p[DEV_W-1:0]);
  endfunction

  // second fold and one conditional subtract
  function automatic logic [DEV_W-1:0] reduce_fold(input logic [FOLD_W-1:0] f,
                                                   input logic [7:0]        ofs,
                                                   input logic [31:0]       m);
    logic [FOLD_W-1:0] t;
    t = FOLD_W'(f[DEV_W] ? ofs : 8'd0) + FOLD_W'(f[DEV_W-1:0]);
    return (t >= m) ? DEV_W'(t - m) : t[DEV_W-1:0];
  endfunction

endpackage

// ===== design/clsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// clsr_ctrl
// sequencer for reseed warm-up and draw steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clsr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  reseed_i,
  output logic                  in_stall_o,
  input  logic                  out_stall_i,
  input  clsr_pkg::clsr_status_t status_i,
  output clsr_pkg::clsr_cmd_t   cmd_o
);
  import clsr_pkg::*;

  clsr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (reseed_i) begin
            cmd_o.seed_ld = 1'b1;
            state_d       = ST_W_MUL;
          end else begin
            cmd_o.mul_en = 1'b1;
            state_d      = ST_D_FOLD;
          end
        end
      end
      ST_W_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_W_FOLD;
      end
      ST_W_FOLD: begin
        cmd_o.fold_en = 1'b1;
        state_d       = ST_W_RED;
      end
      ST_W_RED: begin
        cmd_o.red_g1  = 1'b1;
        cmd_o.warm_wr = 1'b1;
        state_d       = status_i.step_zero ? ST_D_MUL : ST_W_MUL;
      end
      ST_D_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_D_FOLD;
      end
      ST_D_FOLD: begin
        cmd_o.fold_en = 1'b1;
        state_d       = ST_D_RED;
      end
      ST_D_RED: begin
        cmd_o.red_g1 = 1'b1;
        cmd_o.red_g2 = 1'b1;
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_D_OUT;
      end
      ST_D_OUT: begin
        // commit only once the output register is free
        if (!status_i.out_pend || !out_stall_i) begin
          cmd_o.out_wr = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/clsr_dp.sv =====
// ----------------------------------------------------------------------------
// clsr_dp
// generator registers, modular multipliers, shuffle table and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clsr_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  clsr_pkg::clsr_cmd_t          cmd_i,
  output clsr_pkg::clsr_status_t       status_o,
  input  logic [clsr_pkg::DEV_W-1:0]   seed_value_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [clsr_pkg::DEV_W-1:0]   deviate_o
);
  import clsr_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 8);
  localparam longint unsigned BUCKET = 64'd1 + (64'(MOD1) - 64'd1) / 64'(TABLE_DEPTH);
  localparam longint unsigned RECIP  = (64'd1 << IDX_SHIFT) / BUCKET;
  localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
  localparam int unsigned QP_W    = DEV_W + RECIP_W;

  localparam logic [SW-1:0]      STEP_INIT = SW'(TABLE_DEPTH + 7);
  localparam logic [SW-1:0]      STEP_TD   = SW'(TABLE_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
  localparam logic [31:0]        BUCKET_C  = 32'(BUCKET);
  localparam logic [IW:0]        IDX_MAX   = (IW + 1)'(TABLE_DEPTH - 1);

  logic [DEV_W-1:0]  g1_q, g2_q, last_q;
  logic [PROD_W-1:0] p1_q, p2_q;
  logic [FOLD_W-1:0] f1_q, f2_q;
  logic [IW:0]       q0_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic [SW-1:0]     step_q;
  logic [DEV_W-1:0]  rd_q;
  logic              rd_vld_q;
  logic [TABLE_DEPTH-1:0] vld_q;
  logic [DEV_W-1:0]  dev_q;
  logic              out_vld_q;
  logic [DEV_W-1:0]  tbl_mem [TABLE_DEPTH];

  logic [DEV_W-1:0]  seed_s, seed_m1, seed_m2;
  logic [DEV_W-1:0]  r1, r2;
  logic [QP_W-1:0]   qp;
  logic [31:0]       rem;
  logic [IW:0]       idx_c;
  logic [DEV_W-1:0]  picked;
  logic [31:0]       val32;
  logic [DEV_W-1:0]  dev_d;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  logic [DEV_W-1:0]  mem_wd;
  logic              warm_in_tbl;

  // seed clamp and reduction by each modulus
  always_comb begin
    seed_s  = (seed_value_i == '0) ? DEV_W'(1) : seed_value_i;
    seed_m1 = (32'(seed_s) >= MOD1) ? DEV_W'(32'(seed_s) - MOD1) : seed_s;
    seed_m2 = (32'(seed_s) >= MOD2) ? DEV_W'(32'(seed_s) - MOD2) : seed_s;
  end

  assign r1 = reduce_fold(f1_q, OFS1, MOD1);
  assign r2 = reduce_fold(f2_q, OFS2, MOD2);

  // index estimate by reciprocal, then one correction step
  assign qp = QP_W'(last_q) * QP_W'(RECIP_C);
  always_comb begin
    rem   = 32'(last_q) - 32'(q0_q) * BUCKET_C;
    idx_c = (rem >= BUCKET_C) ? q0_q + 1'b1 : q0_q;
    idx_d = (idx_c > IDX_MAX) ? IDX_MAX[IW-1:0] : idx_c[IW-1:0];
  end

  // subtract second generator, fold up on underflow
  always_comb begin
    picked = rd_vld_q ? rd_q : '0;
    if (picked > g2_q) begin
      val32 = 32'(picked) - 32'(g2_q);
    end else begin
      val32 = (MOD1 - 32'd1) - (32'(g2_q) - 32'(picked));
    end
    dev_d = val32[DEV_W-1:0];
  end

  assign warm_in_tbl = cmd_i.warm_wr && (step_q < STEP_TD);
  assign mem_we      = warm_in_tbl || cmd_i.out_wr;
  assign mem_wa      = cmd_i.out_wr ? idx_q : step_q[IW-1:0];
  assign mem_wd      = cmd_i.out_wr ? g1_q : r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_q      <= GEN1_RST;
      g2_q      <= GEN2_RST;
      last_q    <= '0;
      step_q    <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.seed_ld) begin
        g1_q   <= seed_m1;
        g2_q   <= seed_m2;
        step_q <= STEP_INIT;
      end
      if (cmd_i.red_g1) begin
        g1_q <= r1;
      end
      if (cmd_i.red_g2) begin
        g2_q <= r2;
      end
      if (cmd_i.warm_wr) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          last_q <= r1;
        end
      end
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (cmd_i.out_wr) begin
        last_q    <= dev_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // pipeline payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p1_q <= PROD_W'(g1_q) * PROD_W'(MUL1);
      p2_q <= PROD_W'(g2_q) * PROD_W'(MUL2);
      q0_q <= (IW + 1)'(qp >> IDX_SHIFT);
    end
    if (cmd_i.fold_en) begin
      f1_q  <= fold_prod(p1_q, OFS1);
      f2_q  <= fold_prod(p2_q, OFS2);
      idx_q <= idx_d;
    end
    if (cmd_i.out_wr) begin
      dev_q <= dev_d;
    end
  end

  // shuffle table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.mem_rd) begin
      rd_q     <= tbl_mem[idx_q];
      rd_vld_q <= vld_q[idx_q];
    end
  end

  assign status_o.step_zero = (step_q == '0);
  assign status_o.out_pend  = out_vld_q;
  assign out_valid_o        = out_vld_q;
  assign deviate_o          = dev_q;

endmodule

// ===== design/combined_lcg_shuffle_rng_core.sv =====
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_core
// combined multiplicative generator pair with a shuffle table
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one request of reseed_i and
//   seed_value_i; a request with reseed_i low draws the next deviate, one with
//   reseed_i high reloads both generators from the seed (zero taken as one),
//   warms the table and then draws
//   output channel: out_valid_o / out_stall_i carry deviate_o, 1..2147483562,
//   exactly one per request
//   a draw runs the three-stage modular multiply (product, first fold, final
//   fold), then the table read, then the table write together with the
//   output register load; a new request is taken only after that write
//   a reseed adds TABLE_DEPTH+8 serial multiplies ahead of the draw
//   in_stall_o is high while a request is being worked on; a new request may
//   be accepted while the last result still waits in the output register
//   if the receiver stalls, the finished result holds and the next draw waits
//   at its final step until the output register frees up
//   reset puts the generators at 1 and 123456789, the last output at zero and
//   every table entry at zero, by per-entry valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "combined_lcg_shuffle_rng_core_macros.svh"

module combined_lcg_shuffle_rng_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       reseed_i,
  input  logic [clsr_pkg::DEV_W-1:0] seed_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [clsr_pkg::DEV_W-1:0] deviate_o
);
  import clsr_pkg::*;

  clsr_cmd_t    cmd;
  clsr_status_t status;

  // sequencer: walks warm-up and draw steps
  clsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .reseed_i    (reseed_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: generators, shuffle table and output register
  clsr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .seed_value_i (seed_value_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .deviate_o    (deviate_o)
  );

  // a held result must never be overwritten by the next draw
  `CLSR_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.out_wr && out_valid_o && out_stall_i, "result overwritten while stalled")
  // each accepted request closes the input until its work is done
  `CLSR_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "input open right after a request")
  // delivered deviates stay inside the folded range
  `CLSR_ASSERT(a_dev_range, clk_i, rst_ni, out_valid_o |-> ((deviate_o != '0) && (deviate_o <= 31'd2147483562)), "deviate out of range")

endmodule

// ===== bench/combined_lcg_shuffle_rng_core_test.sv =====
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_core_test
// self-checking bench for the combined generator with shuffle table: draws
// from the reset state, reseeds at the seed extremes and on both moduli, a
// stuck first generator, then a long random stream of draws and reseeds.
// every deviate is checked against a cycle-free predictor of the generator
// pair and table, with random idling on the request and result sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_core_test;
  import clsr_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned BUCKET_SIZE  = 1 + (MOD1 - 32'd1) / TABLE_DEPTH;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PRINT_LIMIT  = 40;

  // request kinds
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             reseed_i;
  logic [DEV_W-1:0] seed_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [DEV_W-1:0] deviate_o;

  // predictor state: both generators, last deviate and the shuffle table
  logic [DEV_W-1:0] gen_one;
  logic [DEV_W-1:0] gen_two;
  logic [DEV_W-1:0] last_dev;
  logic [DEV_W-1:0] shuffle_mem [TABLE_DEPTH];

  logic [DEV_W-1:0] pending_deviates [$];
  logic [DEV_W-1:0] expected_dev;

  int unsigned sent_requests;
  int unsigned reseed_count;
  int unsigned checked_deviates;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          send_quiet;
  bit          recv_quiet;
  int unsigned recv_phase_left;
  int unsigned stall_left;

  combined_lcg_shuffle_rng_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .reseed_i    (reseed_i),
    .seed_value_i(seed_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .deviate_o   (deviate_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [DEV_W-1:0] mul_mod(input logic [DEV_W-1:0] x,
                                               input logic [15:0]      a,
                                               input logic [31:0]      m);
    logic [63:0] prod;
    prod = 64'(x) * 64'(a);
    return DEV_W'(prod % 64'(m));
  endfunction

  function automatic void rng_reset();
    gen_one  = GEN1_RST;
    gen_two  = GEN2_RST;
    last_dev = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) shuffle_mem[i] = '0;
  endfunction

  // advances the predictor by one request and returns the deviate it yields
  function automatic logic [DEV_W-1:0] draw_expected(input logic             op,
                                                     input logic [DEV_W-1:0] seed);
    logic [DEV_W-1:0] s;
    logic [DEV_W-1:0] picked;
    logic [DEV_W-1:0] value;
    int unsigned      idx;
    int               step;
    if (op == OP_RESEED) begin
      s       = (seed == '0) ? DEV_W'(1) : seed;
      gen_one = DEV_W'(32'(s) % MOD1);
      gen_two = DEV_W'(32'(s) % MOD2);
      // warm-up: the last TABLE_DEPTH values fill the table from the top down
      for (step = TABLE_DEPTH + 7; step >= 0; step--) begin
        gen_one = mul_mod(gen_one, MUL1, MOD1);
        if (step < TABLE_DEPTH) shuffle_mem[step] = gen_one;
      end
      last_dev = shuffle_mem[0];
    end
    gen_one = mul_mod(gen_one, MUL1, MOD1);
    gen_two = mul_mod(gen_two, MUL2, MOD2);
    idx = 32'(last_dev) / BUCKET_SIZE;
    if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
    picked           = shuffle_mem[idx];
    shuffle_mem[idx] = gen_one;
    if (picked > gen_two) begin
      value = picked - gen_two;
    end else begin
      value = DEV_W'(MOD1 - 32'd1 - 32'(gen_two - picked));
    end
    last_dev = value;
    return value;
  endfunction

  // ---------------------------------------------------------------------------
  // shared helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // full-range seeds plus the tiny ones and those around both moduli
  function automatic logic [DEV_W-1:0] pick_seed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return DEV_W'($urandom);
    if (r < 80) return DEV_W'($urandom_range(0, 3));
    if (r < 90) return DEV_W'(MOD1 - 32'd3 + 32'($urandom_range(0, 6)));
    return DEV_W'(MOD2 - 32'd3 + 32'($urandom_range(0, 6)));
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // one request through the valid/stall handshake; valid stays high when
  // the next request follows without a gap
  task automatic send_request(input logic op, input logic [DEV_W-1:0] seed);
    int unsigned gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    reseed_i     <= op;
    seed_value_i <= seed;
    do @(posedge clk_i); while (in_stall_o);
    pending_deviates.push_back(draw_expected(op, seed));
    sent_requests++;
    if (op == OP_RESEED) reseed_count++;
  endtask

  // hold off new requests until every outstanding deviate has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_deviates.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: check each accepted deviate, then choose the next stall
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_deviates.size() == 0) begin
          report_mismatch($sformatf("deviate %0d with no request outstanding", deviate_o));
        end else begin
          expected_dev = pending_deviates.pop_front();
          checked_deviates++;
          if (deviate_o !== expected_dev) begin
            report_mismatch($sformatf("deviate %0d, expected %0d", deviate_o, expected_dev));
          end
        end
      end
      // stretches with no stalling alternate with random stalling
      if (recv_phase_left == 0) begin
        recv_quiet      = ($urandom_range(0, 3) == 0);
        recv_phase_left = $urandom_range(50, 400);
      end else begin
        recv_phase_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!recv_quiet && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // watchdog: too long without any handshake on either side ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("[combined_lcg_shuffle_rng_core] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // draws straight from the reset values, zero table entries included
  task automatic test_draw_from_reset();
    repeat (6) send_request(OP_DRAW, DEV_W'($urandom));
  endtask

  // seed of zero, one, all ones and the values around both moduli
  task automatic test_seed_extremes();
    send_request(OP_RESEED, '0);
    send_request(OP_DRAW, '1);
    send_request(OP_RESEED, DEV_W'(1));
    send_request(OP_RESEED, '1);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, DEV_W'(MOD2 - 32'd1));
    send_request(OP_RESEED, DEV_W'(MOD2));
    send_request(OP_DRAW, DEV_W'(31'h2AAAAAAA));
    send_request(OP_RESEED, DEV_W'(MOD2 + 32'd1));
    send_request(OP_RESEED, DEV_W'(MOD1 - 32'd1));
    send_request(OP_DRAW, DEV_W'(31'h55555555));
    send_request(OP_RESEED, DEV_W'(MOD1 + 32'd1));
  endtask

  // a seed equal to the first modulus pins the first generator at zero
  task automatic test_stuck_first_generator();
    send_request(OP_RESEED, DEV_W'(MOD1));
    repeat (4) send_request(OP_DRAW, DEV_W'($urandom));
    drain_results();
  endtask

  // long stream, mostly draws with occasional reseeds
  task automatic test_random_stream();
    logic op;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) drain_results();
      op = ($urandom_range(0, 99) < 5) ? OP_RESEED : OP_DRAW;
      send_request(op, pick_seed());
    end
    send_quiet = 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    reseed_i         = OP_DRAW;
    seed_value_i     = '0;
    out_stall_i      = 1'b0;
    sent_requests    = 0;
    reseed_count     = 0;
    checked_deviates = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    send_quiet       = 1'b0;
    recv_quiet       = 1'b0;
    recv_phase_left  = 0;
    stall_left       = 0;
    rng_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_draw_from_reset();
    test_seed_extremes();
    test_stuck_first_generator();
    test_random_stream();

    drain_results();
    repeat (30) @(posedge clk_i);
    if (pending_deviates.size() != 0) begin
      report_mismatch($sformatf("%0d deviates never arrived", pending_deviates.size()));
    end
    $display("ran %0d requests, %0d of them reseeds, checked %0d deviates",
             sent_requests, reseed_count, checked_deviates);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("[combined_lcg_shuffle_rng_core] OK");
    end else begin
      $display("[combined_lcg_shuffle_rng_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== combined_lcg_shuffle_rng_core.f =====
+incdir+design
design/clsr_pkg.sv
design/clsr_ctrl.sv
design/clsr_dp.sv
design/combined_lcg_shuffle_rng_core.sv
bench/combined_lcg_shuffle_rng_core_test.sv
